// ===== src/pair_delta_r_squared_unit_macros.svh =====
// Assertion macros shared by the checker of the pair distance unit.
// No dependencies; include by bare file name.
`ifndef PAIR_DELTA_R_SQUARED_UNIT_MACROS_SVH
`define PAIR_DELTA_R_SQUARED_UNIT_MACROS_SVH

// Antecedent implies consequent on every clock edge outside reset.
`define PRDR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("assertion failed");

// Expression holds on every clock edge outside reset.
`define PRDR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`endif

// ===== src/prdr_pkg.sv =====
// Shared types, constants and tables of the pair distance unit.
// No dependencies.
package prdr_pkg;

    localparam int MAX_PARTICLES = 16;
    localparam int COMPONENTS    = 4;
    localparam int ADDR_W        = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    localparam int LOG_STEPS     = 24;
    localparam int CORDIC_STEPS  = 21;
    // store read, two prep stages, the step chain, four finishing stages
    localparam int PIPE_LATENCY  = LOG_STEPS + 7;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] COMP_E  = 2'd0;
    localparam logic [1:0] COMP_PX = 2'd1;
    localparam logic [1:0] COMP_PY = 2'd2;
    localparam logic [1:0] COMP_PZ = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_UNDEF = 2'd2;

    typedef logic signed [23:0] comp_val_t;
    typedef logic signed [35:0] cord_t;
    typedef logic signed [24:0] ang_t;

    localparam ang_t ANG_PI = 25'sd3294199;
    localparam logic signed [25:0] ANG_TWO_PI = 26'sd6588398;
    localparam logic [28:0] HALF_LN2_Q30 = 29'd372130559;

    typedef struct packed {
        logic       func;
        logic [3:0] index_a;
        logic [3:0] index_b;
        logic [1:0] component;
        comp_val_t  value;
    } req_t;

    typedef struct packed {
        logic [23:0] distance_sq;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        comp_val_t e;
        comp_val_t px;
        comp_val_t py;
        comp_val_t pz;
    } mom_t;

    typedef struct packed {
        logic valid;
        logic zero_a;
        logic zero_b;
        mom_t a;
        mom_t b;
    } pair_t;

    typedef struct packed {
        logic              valid;
        logic              undef;
        logic [3:0][30:0]  mant;
        logic [3:0][4:0]   expo;
        logic [3:0][23:0]  frac;
        cord_t [1:0]       cx;
        cord_t [1:0]       cy;
        ang_t [1:0]        cz;
    } lane_t;

    function automatic ang_t atan_q20(input logic [4:0] step);
        ang_t a;
        case (step)
            5'd0:    a = 25'sd823550;
            5'd1:    a = 25'sd486170;
            5'd2:    a = 25'sd256879;
            5'd3:    a = 25'sd130396;
            5'd4:    a = 25'sd65451;
            5'd5:    a = 25'sd32757;
            5'd6:    a = 25'sd16383;
            5'd7:    a = 25'sd8192;
            5'd8:    a = 25'sd4096;
            5'd9:    a = 25'sd2048;
            5'd10:   a = 25'sd1024;
            5'd11:   a = 25'sd512;
            5'd12:   a = 25'sd256;
            5'd13:   a = 25'sd128;
            5'd14:   a = 25'sd64;
            5'd15:   a = 25'sd32;
            5'd16:   a = 25'sd16;
            5'd17:   a = 25'sd8;
            5'd18:   a = 25'sd4;
            5'd19:   a = 25'sd2;
            5'd20:   a = 25'sd1;
            default: a = 25'sd0;
        endcase
        return a;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [3:0] idx);
        return ADDR_W'(idx);
    endfunction

    function automatic logic in_range(input logic [3:0] idx);
        return int'(idx) < MAX_PARTICLES;
    endfunction

endpackage

// ===== src/prdr_store.sv =====
// Four-momentum store: one memory per component, two registered read ports.
// Depends on prdr_pkg.
module prdr_store (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  prdr_pkg::req_t req,
    output prdr_pkg::pair_t pair
);
    import prdr_pkg::*;

    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              wr_en;
    comp_val_t         rd_a_reg [COMPONENTS];
    comp_val_t         rd_b_reg [COMPONENTS];
    logic              valid_reg;
    logic              zero_a_reg;
    logic              zero_b_reg;

    assign addr_a = addr_of(req.index_a);
    assign addr_b = addr_of(req.index_b);
    assign wr_en  = start && (req.func == FUNC_LOAD) && in_range(req.index_a);

    for (genvar c = 0; c < COMPONENTS; c++) begin : gen_comp
        logic [23:0] mem [MAX_PARTICLES];

        always_ff @(posedge clk)
        begin
            if (wr_en && (req.component == 2'(c)))
            begin
                mem[addr_a] <= req.value;
            end
            rd_a_reg[c] <= mem[addr_a];
            rd_b_reg[c] <= mem[addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start && (req.func == FUNC_QUERY);
        end
    end

    // out-of-range particles read as all zero
    always_ff @(posedge clk)
    begin
        zero_a_reg <= !in_range(req.index_a);
        zero_b_reg <= !in_range(req.index_b);
    end

    always_comb
    begin
        pair.valid  = valid_reg;
        pair.zero_a = zero_a_reg;
        pair.zero_b = zero_b_reg;
        pair.a.e    = rd_a_reg[COMP_E];
        pair.a.px   = rd_a_reg[COMP_PX];
        pair.a.py   = rd_a_reg[COMP_PY];
        pair.a.pz   = rd_a_reg[COMP_PZ];
        pair.b.e    = rd_b_reg[COMP_E];
        pair.b.px   = rd_b_reg[COMP_PX];
        pair.b.py   = rd_b_reg[COMP_PY];
        pair.b.pz   = rd_b_reg[COMP_PZ];
    end

endmodule

// ===== src/prdr_prep.sv =====
// Two prep stages: light-cone sums, rapidity check, CORDIC pre-rotation,
// then log2 normalization. Depends on prdr_pkg.
module prdr_prep (
    input  logic            clk,
    input  logic            rst_n,
    input  prdr_pkg::pair_t pair,
    output prdr_pkg::lane_t lane_out
);
    import prdr_pkg::*;

    logic             a_valid_reg;
    logic             a_undef_reg;
    logic             a_undef_next;
    logic [3:0][23:0] a_n_reg;
    logic [3:0][23:0] a_n_next;
    cord_t [1:0]      a_cx_reg;
    cord_t [1:0]      a_cy_reg;
    ang_t [1:0]       a_cz_reg;
    cord_t [1:0]      a_cx_next;
    cord_t [1:0]      a_cy_next;
    ang_t [1:0]       a_cz_next;

    logic             b_valid_reg;
    lane_t            b_data_reg;
    lane_t            b_data_next;

    always_comb
    begin
        mom_t                m;
        logic signed [24:0]  ew;
        logic signed [24:0]  zw;
        logic signed [24:0]  zabs;
        cord_t               x0;
        cord_t               y0;
        ang_t                z0;
        a_undef_next = 1'b0;
        a_n_next     = '0;
        a_cx_next    = '0;
        a_cy_next    = '0;
        a_cz_next    = '0;
        for (int p = 0; p < 2; p++)
        begin
            if (p == 0)
                m = pair.zero_a ? '0 : pair.a;
            else
                m = pair.zero_b ? '0 : pair.b;
            ew   = {m.e[23], m.e};
            zw   = {m.pz[23], m.pz};
            zabs = zw[24] ? -zw : zw;
            if (ew <= zabs)
                a_undef_next = 1'b1;
            a_n_next[2*p]   = 24'(ew + zw);
            a_n_next[2*p+1] = 24'(ew - zw);
            x0 = {{4{m.px[23]}}, m.px, 8'd0};
            y0 = {{4{m.py[23]}}, m.py, 8'd0};
            z0 = '0;
            // left half plane: rotate by pi toward the right half
            if (x0 < 0)
            begin
                z0 = (y0 >= 0) ? ANG_PI : -ANG_PI;
                x0 = -x0;
                y0 = -y0;
            end
            a_cx_next[p] = x0;
            a_cy_next[p] = y0;
            a_cz_next[p] = z0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= pair.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_undef_reg <= a_undef_next;
        a_n_reg     <= a_n_next;
        a_cx_reg    <= a_cx_next;
        a_cy_reg    <= a_cy_next;
        a_cz_reg    <= a_cz_next;
        b_data_reg  <= b_data_next;
    end

    // normalize each operand to a Q1.30 mantissa
    always_comb
    begin
        logic [4:0] k;
        b_data_next       = '0;
        b_data_next.undef = a_undef_reg;
        b_data_next.cx    = a_cx_reg;
        b_data_next.cy    = a_cy_reg;
        b_data_next.cz    = a_cz_reg;
        for (int j = 0; j < 4; j++)
        begin
            k = '0;
            for (int b = 0; b < 24; b++)
            begin
                if (a_n_reg[j][b])
                    k = 5'(b);
            end
            b_data_next.expo[j] = k;
            b_data_next.mant[j] = 31'(a_n_reg[j]) << (5'd30 - k);
        end
    end

    always_comb
    begin
        lane_out       = b_data_reg;
        lane_out.valid = b_valid_reg;
    end

endmodule

// ===== src/prdr_stage.sv =====
// One step of the chain: a log2 square-and-compare step on four operands and,
// in the first CORDIC_STEPS steps, one CORDIC vectoring rotation on two particles. Depends on prdr_pkg.
module prdr_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [4:0]      step_idx,
    input  prdr_pkg::lane_t lane_in,
    output prdr_pkg::lane_t lane_out
);
    import prdr_pkg::*;

    logic  valid_reg;
    lane_t data_reg;
    lane_t data_next;

    always_comb
    begin
        logic [61:0] sq;
        logic [31:0] t;
        logic [4:0]  bitpos;
        cord_t       x;
        cord_t       y;
        cord_t       sx;
        cord_t       sy;
        ang_t        z;
        data_next = lane_in;
        bitpos    = 5'(LOG_STEPS - 1) - step_idx;
        for (int j = 0; j < 4; j++)
        begin
            sq = 62'(lane_in.mant[j]) * 62'(lane_in.mant[j]);
            t  = sq[61:30];
            if (t[31])
            begin
                data_next.mant[j]         = t[31:1];
                data_next.frac[j][bitpos] = 1'b1;
            end
            else
            begin
                data_next.mant[j] = t[30:0];
            end
        end
        for (int p = 0; p < 2; p++)
        begin
            x  = lane_in.cx[p];
            y  = lane_in.cy[p];
            z  = lane_in.cz[p];
            sx = x >>> step_idx;
            sy = y >>> step_idx;
            // rotate only in the first CORDIC_STEPS steps; hold once the residual reaches zero
            if (step_idx < 5'(CORDIC_STEPS))
            begin
                if (y > 0)
                begin
                    x = x + sy;
                    y = y - sx;
                    z = z + atan_q20(step_idx);
                end
                else if (y < 0)
                begin
                    x = x - sy;
                    y = y + sx;
                    z = z - atan_q20(step_idx);
                end
            end
            data_next.cx[p] = x;
            data_next.cy[p] = y;
            data_next.cz[p] = z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= lane_in.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        lane_out       = data_reg;
        lane_out.valid = valid_reg;
    end

endmodule

// ===== src/prdr_finish.sv =====
// Four finishing stages: log sum and azimuth fold, scale by ln(2)/2,
// squares, round and saturate. Depends on prdr_pkg.
module prdr_finish (
    input  logic            clk,
    input  logic            rst_n,
    input  prdr_pkg::lane_t lane_in,
    output logic            done,
    output prdr_pkg::rsp_t  rsp
);
    import prdr_pkg::*;

    logic               f1_valid_reg, f2_valid_reg, f3_valid_reg, done_reg;
    logic               f1_undef_reg, f2_undef_reg, f3_undef_reg;
    logic signed [31:0] f1_lsum_reg;
    logic signed [31:0] f1_lsum_next;
    logic [21:0]        f1_dphi_reg;
    logic [21:0]        f1_dphi_next;
    logic [59:0]        f2_prod_reg;
    logic [25:0]        f2_dp_reg;
    logic [30:0]        lmag;
    logic [60:0]        rnd;
    logic [61:0]        f3_dy2_reg;
    logic [51:0]        f3_dp2_reg;
    logic [63:0]        total;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    always_comb
    begin
        logic signed [25:0] d;
        f1_lsum_next = $signed({3'b0, lane_in.expo[0], lane_in.frac[0]})
                     - $signed({3'b0, lane_in.expo[1], lane_in.frac[1]})
                     - $signed({3'b0, lane_in.expo[2], lane_in.frac[2]})
                     + $signed({3'b0, lane_in.expo[3], lane_in.frac[3]});
        d = 26'(lane_in.cz[0]) - 26'(lane_in.cz[1]);
        if (d < 0)
            d = -d;
        // fold into [0, pi]
        if (d > 26'(ANG_PI))
            d = ANG_TWO_PI - d;
        if (d < 0)
            d = '0;
        f1_dphi_next = 22'(d);
    end

    assign lmag  = f1_lsum_reg[31] ? 31'(-f1_lsum_reg) : 31'(f1_lsum_reg);
    assign rnd   = 61'(f2_prod_reg) + (61'(1) << 29);
    assign total = 64'(f3_dy2_reg) + 64'(f3_dp2_reg) + (64'(1) << 31);

    always_comb
    begin
        if (f3_undef_reg)
        begin
            rsp_next.distance_sq = '0;
            rsp_next.status      = ST_UNDEF;
        end
        else if (total[63:32] > 32'h00FF_FFFF)
        begin
            rsp_next.distance_sq = 24'hFF_FFFF;
            rsp_next.status      = ST_SAT;
        end
        else
        begin
            rsp_next.distance_sq = total[55:32];
            rsp_next.status      = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= lane_in.valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            done_reg     <= f3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_undef_reg <= lane_in.undef;
        f1_lsum_reg  <= f1_lsum_next;
        f1_dphi_reg  <= f1_dphi_next;
        f2_undef_reg <= f1_undef_reg;
        f2_prod_reg  <= 60'(lmag) * 60'(HALF_LN2_Q30);
        f2_dp_reg    <= {f1_dphi_reg, 4'd0};
        f3_undef_reg <= f2_undef_reg;
        f3_dy2_reg   <= 62'(rnd[60:30]) * 62'(rnd[60:30]);
        f3_dp2_reg   <= 52'(f2_dp_reg) * 52'(f2_dp_reg);
        rsp_reg      <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== src/pair_delta_r_squared_unit.sv =====
// Top level of the pair rapidity-azimuth distance unit.
// Depends on prdr_pkg, prdr_store, prdr_prep, prdr_stage, prdr_finish.
module pair_delta_r_squared_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  prdr_pkg::req_t req,
    output logic           done,
    output prdr_pkg::rsp_t rsp
);
    // Fully pipelined: an item is taken in every cycle that start is high,
    // and busy stays low. A load item writes one momentum component and
    // gives no result; a query item gives its result on rsp, marked by a
    // one-cycle done strobe, in issue order. Its path runs through one store
    // read, two prep stages, the chain of 24 log2 square-and-compare stages
    // (which also carry the 21 CORDIC rotations) and four finishing stages.
    // The receiver cannot hold results off, so done must be taken when it
    // shows. A load is seen by a query taken in the next cycle. Querying a
    // particle that was never loaded gives an arbitrary result.
    import prdr_pkg::*;

    pair_t pair;
    lane_t lanes [LOG_STEPS+1];

    // no stall source anywhere in the pipeline
    assign busy = 1'b0;

    // read both particles; loads write here too
    prdr_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .pair  (pair)
    );

    // sums, rapidity check, pre-rotation, normalize
    prdr_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .pair     (pair),
        .lane_out (lanes[0])
    );

    // one log2 bit per stage; one CORDIC rotation in each of the first CORDIC_STEPS stages
    for (genvar s = 0; s < LOG_STEPS; s++) begin : gen_step
        prdr_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .step_idx (5'(s)),
            .lane_in  (lanes[s]),
            .lane_out (lanes[s+1])
        );
    end

    // combine, square, round, saturate
    prdr_finish u_finish (
        .clk     (clk),
        .rst_n   (rst_n),
        .lane_in (lanes[LOG_STEPS]),
        .done    (done),
        .rsp     (rsp)
    );

endmodule

// ===== src/prdr_checker.sv =====
// Port-level checks of the pair distance unit, bound to its top level.
// Depends on prdr_pkg and pair_delta_r_squared_unit_macros.svh.
`include "pair_delta_r_squared_unit_macros.svh"
module prdr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input prdr_pkg::req_t req,
    input logic           done,
    input prdr_pkg::rsp_t rsp
);
    import prdr_pkg::*;

    `PRDR_ASSERT_IMPLY(a_query_done, clk, rst_n, start && !busy && req.func == FUNC_QUERY, ##PIPE_LATENCY done)
    `PRDR_ASSERT_IMPLY(a_done_query, clk, rst_n, done, $past(start && !busy && req.func == FUNC_QUERY, PIPE_LATENCY))
    `PRDR_ASSERT_IMPLY(a_sat_value, clk, rst_n, done && rsp.status == ST_SAT, rsp.distance_sq == 24'hFF_FFFF)
    `PRDR_ASSERT_ALWAYS(a_status, clk, rst_n, !done || rsp.status == ST_OK || rsp.status == ST_SAT || (rsp.status == ST_UNDEF && rsp.distance_sq == 24'd0))

endmodule

bind pair_delta_r_squared_unit prdr_checker u_checker (.*);
